>>> src/vector2_angle_between_top_assert.svh
// Assertion macros for the vector angle block checker.
// Needs i_clk and i_rst_n in the scope of use.
`ifndef VECTOR2_ANGLE_BETWEEN_TOP_ASSERT_SVH
`define VECTOR2_ANGLE_BETWEEN_TOP_ASSERT_SVH

// same-cycle implication
`define VAB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define VAB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/vab_pkg.sv
// Shared types, constants and CORDIC angle table for the vector angle block.
// No dependencies.
`timescale 1ns / 1ps
package vab_pkg;

    localparam int ANGLE_W = 17;
    localparam int NORM_W  = 29;
    localparam int XY_W    = 33;
    localparam int Z_W     = 29;
    localparam int RND_SH  = 11;

    localparam logic signed [Z_W-1:0]     HALF_PI_Q24 = 29'sd26353589;
    localparam logic signed [Z_W-1:0]     PI_Q24      = 29'sd52707179;
    localparam logic signed [Z_W-1:0]     RND_HALF    = 29'sd1024;
    localparam logic signed [ANGLE_W-1:0] TWO_PI_Q13  = 17'sd51472;

    typedef logic signed [ANGLE_W-1:0] t_angle;

    typedef struct packed {
        logic dneg;
        logic cneg;
        logic deg;
    } t_flags;

    function automatic logic signed [Z_W-1:0] atan_q24(input int unsigned idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = 29'sd13176795;
            1:  v = 29'sd7778716;
            2:  v = 29'sd4110060;
            3:  v = 29'sd2086331;
            4:  v = 29'sd1047214;
            5:  v = 29'sd524117;
            6:  v = 29'sd262123;
            7:  v = 29'sd131069;
            8:  v = 29'sd65536;
            9:  v = 29'sd32768;
            10: v = 29'sd16384;
            11: v = 29'sd8192;
            12: v = 29'sd4096;
            13: v = 29'sd2048;
            14: v = 29'sd1024;
            15: v = 29'sd512;
            16: v = 29'sd256;
            17: v = 29'sd128;
            18: v = 29'sd64;
            19: v = 29'sd32;
            20: v = 29'sd16;
            21: v = 29'sd8;
            22: v = 29'sd4;
            23: v = 29'sd2;
            24: v = 29'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/vab_in_if.sv
// Input channel: two 2D vectors per word.
// No dependencies.
`timescale 1ns / 1ps
interface vab_in_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;

    modport source (output valid, a_x, a_y, b_x, b_y, input ready);
    modport sink   (input valid, a_x, a_y, b_x, b_y, output ready);
endinterface

>>> src/vab_out_if.sv
// Output channel: angle word and degenerate flag.
// No dependencies.
`timescale 1ns / 1ps
interface vab_out_if;
    logic               valid;
    logic               ready;
    logic signed [16:0] angle;
    logic               degenerate;

    modport source (output valid, angle, degenerate, input ready);
    modport sink   (input valid, angle, degenerate, output ready);
endinterface

>>> src/vab_norm_stage.sv
// One step of the normalizing left shift: shifts by SHIFT if the top bits are clear.
// Depends on vab_pkg.
`timescale 1ns / 1ps
module vab_norm_stage
    import vab_pkg::*;
#(
    parameter int W     = 32,
    parameter int SHIFT = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_flags       i_flags,
    input  logic [W-1:0] i_d,
    input  logic [W-1:0] i_c,
    input  logic [W-1:0] i_m,
    output logic         o_valid,
    output t_flags       o_flags,
    output logic [W-1:0] o_d,
    output logic [W-1:0] o_c,
    output logic [W-1:0] o_m
);
    logic         r_valid;
    t_flags       r_flags;
    logic [W-1:0] r_d, r_c, r_m;
    logic         n_sh;

    assign n_sh = (i_m[W-1 -: SHIFT] == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_d     <= n_sh ? (i_d << SHIFT) : i_d;
            r_c     <= n_sh ? (i_c << SHIFT) : i_c;
            r_m     <= n_sh ? (i_m << SHIFT) : i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_d     = r_d;
    assign o_c     = r_c;
    assign o_m     = r_m;
endmodule

>>> src/vab_cordic_stage.sv
// One vectoring CORDIC iteration with its pipeline register.
// Depends on vab_pkg.
`timescale 1ns / 1ps
module vab_cordic_stage
    import vab_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  t_flags                 i_flags,
    input  logic signed [XY_W-1:0] i_x,
    input  logic signed [XY_W-1:0] i_y,
    input  logic signed [Z_W-1:0]  i_z,
    output logic                   o_valid,
    output t_flags                 o_flags,
    output logic signed [XY_W-1:0] o_x,
    output logic signed [XY_W-1:0] o_y,
    output logic signed [Z_W-1:0]  o_z
);
    localparam logic signed [Z_W-1:0] STEP = atan_q24(IDX);

    logic                   r_valid;
    t_flags                 r_flags;
    logic signed [XY_W-1:0] r_x, r_y;
    logic signed [Z_W-1:0]  r_z;
    logic signed [XY_W-1:0] n_xs, n_ys;
    logic                   n_pos;

    assign n_xs  = i_x >>> IDX;
    assign n_ys  = i_y >>> IDX;
    assign n_pos = !i_y[XY_W-1] && (i_y != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            if (n_pos) begin
                r_x <= i_x + n_ys;
                r_y <= i_y - n_xs;
                r_z <= i_z + STEP;
            end else begin
                r_x <= i_x - n_ys;
                r_y <= i_y + n_xs;
                r_z <= i_z - STEP;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_flags = r_flags;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
endmodule

>>> src/vector2_angle_between_top.sv
// Throughput: one word per cycle; the whole pipeline stalls only while the output
// register holds a word not yet taken.
// Reset: synchronous active low; clears valid bits and signed_mode.
// Depends on vab_pkg, vab_in_if, vab_out_if, vab_norm_stage, vab_cordic_stage.
`timescale 1ns / 1ps
module vector2_angle_between_top
    import vab_pkg::*;
#(
    parameter int COORD_WIDTH   = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    vab_in_if.sink     i_in,
    vab_out_if.source  o_out
);
    localparam int PW = 2 * COORD_WIDTH;
    localparam int SW = PW + 1;
    localparam int NW = (PW < NORM_W) ? NORM_W : PW;
    localparam int LS = $clog2(NW);

    logic r_signed_mode;
    logic adv;

    // stage 1: products
    logic                 r_v1;
    logic signed [PW-1:0] r_p_axbx, r_p_ayby, r_p_axby, r_p_aybx;
    // stage 2: dot and cross
    logic                 r_v2;
    logic signed [SW-1:0] r_dot, r_crs;
    // stage 3: magnitudes
    logic                 r_v3;
    t_flags               r_f3;
    logic [NW-1:0]        r_d3, r_c3, r_m3;
    logic [PW-1:0]        n_dmag, n_cmag;

    logic          w_nv [LS+1];
    t_flags        w_nf [LS+1];
    logic [NW-1:0] w_nd [LS+1];
    logic [NW-1:0] w_nc [LS+1];
    logic [NW-1:0] w_nm [LS+1];

    logic                   w_cv [CORDIC_STAGES+1];
    t_flags                 w_cf [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] w_cx [CORDIC_STAGES+1];
    logic signed [XY_W-1:0] w_cy [CORDIC_STAGES+1];
    logic signed [Z_W-1:0]  w_cz [CORDIC_STAGES+1];

    logic [NORM_W-1:0] n_d29, n_c29;
    logic              n_rot;

    logic                  r_ov;
    t_angle                r_angle;
    logic                  r_deg;
    logic signed [Z_W-1:0] n_zc, n_t;
    t_angle                n_theta, n_angle;
    t_flags                n_ff;

    assign adv        = !r_ov || o_out.ready;
    assign i_in.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_signed_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign n_dmag = r_dot[SW-1] ? PW'(-r_dot) : PW'(r_dot);
    assign n_cmag = r_crs[SW-1] ? PW'(-r_crs) : PW'(r_crs);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_axbx <= PW'(i_in.a_x * i_in.b_x);
            r_p_ayby <= PW'(i_in.a_y * i_in.b_y);
            r_p_axby <= PW'(i_in.a_x * i_in.b_y);
            r_p_aybx <= PW'(i_in.a_y * i_in.b_x);
            r_dot    <= SW'(r_p_axbx) + SW'(r_p_ayby);
            r_crs    <= SW'(r_p_axby) - SW'(r_p_aybx);
            r_f3.dneg <= r_dot[SW-1];
            r_f3.cneg <= r_crs[SW-1];
            r_f3.deg  <= (r_dot == '0) && (r_crs == '0);
            r_d3     <= NW'(n_dmag);
            r_c3     <= NW'(n_cmag);
            r_m3     <= (n_dmag > n_cmag) ? NW'(n_dmag) : NW'(n_cmag);
        end
    end

    assign w_nv[0] = r_v3;
    assign w_nf[0] = r_f3;
    assign w_nd[0] = r_d3;
    assign w_nc[0] = r_c3;
    assign w_nm[0] = r_m3;

    for (genvar j = 0; j < LS; j++) begin : g_norm
        vab_norm_stage #(
            .W     (NW),
            .SHIFT (1 << (LS - 1 - j))
        ) u_norm (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_nv[j]),
            .i_flags (w_nf[j]),
            .i_d     (w_nd[j]),
            .i_c     (w_nc[j]),
            .i_m     (w_nm[j]),
            .o_valid (w_nv[j+1]),
            .o_flags (w_nf[j+1]),
            .o_d     (w_nd[j+1]),
            .o_c     (w_nc[j+1]),
            .o_m     (w_nm[j+1])
        );
    end

    // quarter turn when the dot product is negative
    assign n_d29 = w_nd[LS][NW-1 -: NORM_W];
    assign n_c29 = w_nc[LS][NW-1 -: NORM_W];
    assign n_rot = w_nf[LS].dneg && (n_d29 != '0);

    logic                   r_v4;
    t_flags                 r_f4;
    logic signed [XY_W-1:0] r_x4, r_y4;
    logic signed [Z_W-1:0]  r_z4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (adv) begin
            r_v4 <= w_nv[LS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_f4 <= w_nf[LS];
            if (n_rot) begin
                r_x4 <= XY_W'(n_c29);
                r_y4 <= XY_W'(n_d29);
                r_z4 <= HALF_PI_Q24;
            end else begin
                r_x4 <= w_nf[LS].dneg ? -XY_W'(n_d29) : XY_W'(n_d29);
                r_y4 <= XY_W'(n_c29);
                r_z4 <= '0;
            end
        end
    end

    assign w_cv[0] = r_v4;
    assign w_cf[0] = r_f4;
    assign w_cx[0] = r_x4;
    assign w_cy[0] = r_y4;
    assign w_cz[0] = r_z4;

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        vab_cordic_stage #(
            .IDX (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (adv),
            .i_valid (w_cv[i]),
            .i_flags (w_cf[i]),
            .i_x     (w_cx[i]),
            .i_y     (w_cy[i]),
            .i_z     (w_cz[i]),
            .o_valid (w_cv[i+1]),
            .o_flags (w_cf[i+1]),
            .o_x     (w_cx[i+1]),
            .o_y     (w_cy[i+1]),
            .o_z     (w_cz[i+1])
        );
    end

    // clamp to [0, pi], round to Q3.13, mirror on negative cross, zero when degenerate
    always_comb begin
        n_ff = w_cf[CORDIC_STAGES];
        if (w_cz[CORDIC_STAGES][Z_W-1]) begin
            n_zc = '0;
        end else if (w_cz[CORDIC_STAGES] > PI_Q24) begin
            n_zc = PI_Q24;
        end else begin
            n_zc = w_cz[CORDIC_STAGES];
        end
        n_t     = (n_zc + RND_HALF) >>> RND_SH;
        n_theta = ANGLE_W'(n_t);
        if (n_ff.deg) begin
            n_angle = '0;
        end else if (!n_ff.cneg) begin
            n_angle = n_theta;
        end else if (r_signed_mode) begin
            n_angle = -n_theta;
        end else begin
            n_angle = TWO_PI_Q13 - n_theta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= w_cv[CORDIC_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_angle <= n_angle;
            r_deg   <= n_ff.deg;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.angle      = r_angle;
    assign o_out.degenerate = r_deg;
endmodule

>>> src/vab_checker.sv
// Port-level checks for the vector angle block, bound to its top level.
// Depends on vector2_angle_between_top_assert.svh.
`timescale 1ns / 1ps
`include "vector2_angle_between_top_assert.svh"
module vab_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic signed [16:0] i_angle,
    input logic               i_degenerate
);
    localparam logic signed [16:0] ANGLE_MIN = -17'sd25736;
    localparam logic signed [16:0] ANGLE_MAX = 17'sd51472;

    `VAB_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "output word dropped")
    `VAB_ASSERT_NOW(a_deg_zero, i_out_valid && i_degenerate, i_angle == 17'sd0, "degenerate angle")
    `VAB_ASSERT_NOW(a_range, i_out_valid, (i_angle >= ANGLE_MIN) && (i_angle <= ANGLE_MAX), "range")
    `VAB_ASSERT_NOW(a_ready_free, !i_out_valid || i_out_ready, i_in_ready, "input blocked")
endmodule

bind vector2_angle_between_top vab_checker u_vab_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_angle      (o_out.angle),
    .i_degenerate (o_out.degenerate)
);
